/* hdl/ls3d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ls3d_pkg
// Types and constants for the 3D line stepper.
// ----------------------------------------------------------------------------
package ls3d_pkg;

    localparam int COORD_BITS = 16;
    localparam int DELTA_BITS = COORD_BITS + 1;   // doubled absolute delta
    localparam int ERR_BITS   = COORD_BITS + 3;   // signed error term

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [COORD_BITS-1:0] t_delta;
    typedef logic        [DELTA_BITS-1:0] t_dbl_delta;
    typedef logic signed [ERR_BITS-1:0]   t_err;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } t_action;

    typedef struct packed {
        t_action action;
        t_coord  start_x;
        t_coord  start_y;
        t_coord  start_z;
        t_coord  end_x;
        t_coord  end_y;
        t_coord  end_z;
    } t_in_beat;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
        logic   advanced;
        logic   at_end;
    } t_out_beat;

endpackage

/* hdl/line_stepper_3d.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_stepper_3d
// Integer 3D line walker: a load beat sets up a line, each step beat moves
// the point one voxel along the line until its end; every beat reports it.
// ----------------------------------------------------------------------------
// Throughput: 1 beat per cycle when not stalled; set by the error-term update
//   (one add and compare per term on registered state) between accept and
//   result, which is registered in the result buffer.
// A two-entry result buffer keeps the input open for one beat while a result
//   is stalled.
// Reset: synchronous, active low; line state clears to zero, buffer empties.
// ----------------------------------------------------------------------------
module line_stepper_3d (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ls3d_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ls3d_pkg::t_out_beat o_out_data
);

    localparam int CB = ls3d_pkg::COORD_BITS;

    // line state
    ls3d_pkg::t_coord     r_cur [3];
    ls3d_pkg::t_coord     r_end [3];
    logic                 r_neg [3];
    ls3d_pkg::t_dbl_delta r_dd  [3];
    ls3d_pkg::t_axis      r_major;
    ls3d_pkg::t_err       r_err0, r_err1;

    ls3d_pkg::t_coord     n_cur [3];
    ls3d_pkg::t_coord     n_end [3];
    logic                 n_neg [3];
    ls3d_pkg::t_dbl_delta n_dd  [3];
    ls3d_pkg::t_axis      n_major;
    ls3d_pkg::t_err       n_err0, n_err1;

    // result buffer
    logic                r_out_valid, r_skid_valid;
    ls3d_pkg::t_out_beat r_out, r_skid;
    ls3d_pkg::t_out_beat n_beat;

    logic in_fire, out_fire;
    logic cur_at_end, moved;

    assign o_in_stall  = r_skid_valid;
    assign in_fire     = i_in_valid && !r_skid_valid;
    assign out_fire    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign cur_at_end = (r_cur[0] == r_end[0]) && (r_cur[1] == r_end[1]) &&
                        (r_cur[2] == r_end[2]);

    // load setup
    ls3d_pkg::t_coord     ld_s [3];
    ls3d_pkg::t_coord     ld_e [3];
    logic signed [CB:0]   ld_diff [3];
    logic signed [CB:0]   ld_absw [3];
    ls3d_pkg::t_delta     ld_d [3];
    ls3d_pkg::t_delta     ld_dmaj;
    ls3d_pkg::t_dbl_delta ld_dd0, ld_dd1;
    ls3d_pkg::t_axis      ld_major;

    // step datapath
    logic                 mv [3];
    ls3d_pkg::t_dbl_delta dd_maj, dd_a0, dd_a1;
    logic                 mv0, mv1;

    always_comb begin
        ld_s[0] = i_in_data.start_x;
        ld_s[1] = i_in_data.start_y;
        ld_s[2] = i_in_data.start_z;
        ld_e[0] = i_in_data.end_x;
        ld_e[1] = i_in_data.end_y;
        ld_e[2] = i_in_data.end_z;
        for (int i = 0; i < 3; i++) begin
            ld_diff[i] = {ld_e[i][CB-1], ld_e[i]} - {ld_s[i][CB-1], ld_s[i]};
            ld_absw[i] = ld_diff[i][CB] ? -ld_diff[i] : ld_diff[i];
            ld_d[i]    = ld_absw[i][CB-1:0];
        end
        // ties go to x, then y
        if (ld_d[0] >= ld_d[1] && ld_d[0] >= ld_d[2]) begin
            ld_major = ls3d_pkg::AXIS_X;
        end else if (ld_d[1] >= ld_d[0] && ld_d[1] >= ld_d[2]) begin
            ld_major = ls3d_pkg::AXIS_Y;
        end else begin
            ld_major = ls3d_pkg::AXIS_Z;
        end
        case (ld_major)
            ls3d_pkg::AXIS_X: begin
                ld_dmaj = ld_d[0];
                ld_dd0  = {ld_d[1], 1'b0};
                ld_dd1  = {ld_d[2], 1'b0};
            end
            ls3d_pkg::AXIS_Y: begin
                ld_dmaj = ld_d[1];
                ld_dd0  = {ld_d[0], 1'b0};
                ld_dd1  = {ld_d[2], 1'b0};
            end
            default: begin
                ld_dmaj = ld_d[2];
                ld_dd0  = {ld_d[1], 1'b0};
                ld_dd1  = {ld_d[0], 1'b0};
            end
        endcase
    end

    always_comb begin
        mv0 = r_err0 > 0;
        mv1 = r_err1 > 0;
        // term 0 / term 1 axis per major axis
        case (r_major)
            ls3d_pkg::AXIS_X: begin
                dd_maj = r_dd[0];
                dd_a0  = r_dd[1];
                dd_a1  = r_dd[2];
                mv[0]  = 1'b1;
                mv[1]  = mv0;
                mv[2]  = mv1;
            end
            ls3d_pkg::AXIS_Y: begin
                dd_maj = r_dd[1];
                dd_a0  = r_dd[0];
                dd_a1  = r_dd[2];
                mv[0]  = mv0;
                mv[1]  = 1'b1;
                mv[2]  = mv1;
            end
            default: begin
                dd_maj = r_dd[2];
                dd_a0  = r_dd[1];
                dd_a1  = r_dd[0];
                mv[0]  = mv1;
                mv[1]  = mv0;
                mv[2]  = 1'b1;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_cur[i] = r_cur[i];
            n_end[i] = r_end[i];
            n_neg[i] = r_neg[i];
            n_dd[i]  = r_dd[i];
        end
        n_major = r_major;
        n_err0  = r_err0;
        n_err1  = r_err1;
        moved   = 1'b0;
        if (i_in_data.action == ls3d_pkg::ACT_LOAD) begin
            for (int i = 0; i < 3; i++) begin
                n_cur[i] = ld_s[i];
                n_end[i] = ld_e[i];
                n_neg[i] = ld_diff[i][CB];
                n_dd[i]  = {ld_d[i], 1'b0};
            end
            n_major = ld_major;
            n_err0  = $signed({2'b00, ld_dd0}) - $signed({3'b000, ld_dmaj});
            n_err1  = $signed({2'b00, ld_dd1}) - $signed({3'b000, ld_dmaj});
        end else if (!cur_at_end) begin
            for (int i = 0; i < 3; i++) begin
                if (mv[i]) begin
                    n_cur[i] = r_cur[i] + (r_neg[i] ? {CB{1'b1}} : CB'(1));
                end
            end
            n_err0 = r_err0 - (mv0 ? $signed({2'b00, dd_maj}) : '0)
                     + $signed({2'b00, dd_a0});
            n_err1 = r_err1 - (mv1 ? $signed({2'b00, dd_maj}) : '0)
                     + $signed({2'b00, dd_a1});
            moved  = 1'b1;
        end
        n_beat.point_x  = n_cur[0];
        n_beat.point_y  = n_cur[1];
        n_beat.point_z  = n_cur[2];
        n_beat.advanced = moved;
        n_beat.at_end   = (n_cur[0] == n_end[0]) && (n_cur[1] == n_end[1]) &&
                          (n_cur[2] == n_end[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_cur[i] <= '0;
                r_end[i] <= '0;
                r_neg[i] <= 1'b0;
                r_dd[i]  <= '0;
            end
            r_major <= ls3d_pkg::AXIS_X;
            r_err0  <= '0;
            r_err1  <= '0;
        end else if (in_fire) begin
            for (int i = 0; i < 3; i++) begin
                r_cur[i] <= n_cur[i];
                r_end[i] <= n_end[i];
                r_neg[i] <= n_neg[i];
                r_dd[i]  <= n_dd[i];
            end
            r_major <= n_major;
            r_err0  <= n_err0;
            r_err1  <= n_err1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= n_beat;
            end
        end else if (in_fire) begin
            if (r_out_valid) begin
                r_skid <= n_beat;
            end else begin
                r_out <= n_beat;
            end
        end
    end

    // skid entry is only ever filled behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid beat held without a result ahead of it");

    // a step at the endpoint must not move the point
    a_end_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.action == ls3d_pkg::ACT_STEP && cur_at_end)
        |=> ($stable(r_cur[0]) && $stable(r_cur[1]) && $stable(r_cur[2])))
        else $error("point moved on a step at the endpoint");

    // a load always reports no advance (checked with the output register empty)
    a_load_no_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !r_out_valid && i_in_data.action == ls3d_pkg::ACT_LOAD)
        |=> (o_out_valid && !o_out_data.advanced))
        else $error("load beat reported an advance");

endmodule
